// ----- src/srs_pkg.sv -----
// Package for the series reduction statistics block.
// Shared types and constants; no dependencies.
`timescale 1ns / 1ps
package srs_pkg;
    localparam int SampleW = 16;
    localparam int ValueW  = 35;
    localparam int ModeW   = 3;

    typedef enum logic [2:0] {
        MODE_MEAN = 3'd0,
        MODE_SUM  = 3'd1,
        MODE_MIN  = 3'd2,
        MODE_MAX  = 3'd3,
        MODE_MAG  = 3'd4
    } stat_mode_t;

    // controller -> datapath
    typedef struct packed {
        logic accum;      // take sample into accumulators
        logic start_fin;  // latch finish operands, start iteration
        logic iter;       // one divide/root step
        logic clear;      // clear series state
    } srs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic iter_done;
    } srs_stat_t;
endpackage

// ----- src/srs_if.sv -----
// Valid/ready stream interfaces for the input and result items.
// Depends on srs_pkg for field widths.
`timescale 1ns / 1ps
interface srs_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [srs_pkg::SampleW-1:0] sample;
    logic                              last;
    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface srs_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [srs_pkg::ValueW-1:0] value;
    logic                             too_long;
    modport source (output valid, output value, output too_long, input ready);
    modport sink   (input valid, input value, input too_long, output ready);
endinterface

// ----- src/series_reduction_stats.sv -----
// Top level of series reduction statistics: controller plus datapath.
// Depends on srs_pkg, srs_if, srs_ctrl, srs_dp.
//   channel   dir  fields
//   in        in   sample[15:0] signed, last
//   out       out  value[34:0] signed, too_long
//   cfg       in   stat_mode_we, stat_mode_wdata[2:0]
// Samples are taken one per cycle while accumulating. The last sample of a
// series starts the shared divide/root unit at one result bit per cycle;
// the result is then saturated and valid raised. Input is stalled until the
// block accumulates again. Reset clears all accumulators and stat_mode.
// The next series can stream in while a result waits; its last sample waits
// until the output slot is free.
`timescale 1ns / 1ps
module series_reduction_stats
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    srs_in_if.sink      in_ch,
    srs_out_if.source   out_ch,
    input  logic        stat_mode_we,
    input  logic [2:0]  stat_mode_wdata
);
    logic [srs_pkg::ModeW-1:0] mode_reg;
    srs_pkg::srs_cmd_t  cmd;
    srs_pkg::srs_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= '0;
        else if (stat_mode_we)
            mode_reg <= stat_mode_wdata;
    end

    srs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    srs_dp #(.MAX_LEN(MAX_LEN)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (in_ch.sample),
        .stat_mode (mode_reg),
        .cmd       (cmd),
        .stat      (stat),
        .value     (out_ch.value),
        .too_long  (out_ch.too_long)
    );
endmodule

// ----- src/srs_ctrl.sv -----
// Controller for series reduction: accept, iterate, emit.
// Depends on srs_pkg.
`timescale 1ns / 1ps
module srs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  srs_pkg::srs_stat_t  stat,
    output srs_pkg::srs_cmd_t   cmd
);
    typedef enum logic [1:0] {ST_ACC, ST_ITER, ST_OUT} state_t;
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // a new series may start while the previous result waits, except the finish
    // path must not be overwritten; so the last sample waits for the output slot
    logic take;
    assign take = in_valid && in_ready;

    always_comb
    begin
        in_ready = (state_reg == ST_ACC) && !(in_last && out_valid_reg);
        cmd = '0;
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_ACC:
            begin
                cmd.accum = take;
                if (take && in_last)
                begin
                    cmd.start_fin = 1'b1;
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                cmd.iter = 1'b1;
                if (stat.iter_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_next)
                begin
                    out_valid_next = 1'b1;
                    cmd.clear = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ----- src/srs_dp.sv -----
// Datapath: accumulators, shared restoring divide / square root unit, result reg.
// Depends on srs_pkg.
`timescale 1ns / 1ps
module srs_dp
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [srs_pkg::SampleW-1:0]  sample,
    input  logic [srs_pkg::ModeW-1:0]           stat_mode,
    input  srs_pkg::srs_cmd_t                   cmd,
    output srs_pkg::srs_stat_t                  stat,
    output logic signed [srs_pkg::ValueW-1:0]   value,
    output logic                                too_long
);
    localparam int CntW = $clog2(MAX_LEN + 1);
    localparam int SumW = srs_pkg::SampleW + CntW;
    localparam int SqW  = 2 * srs_pkg::SampleW + CntW;
    // radicand is SqW + 16 bits, padded to an even count so bit pairs line up
    localparam int RootW = (SqW + 17) / 2;
    localparam int RadW = 2 * RootW;                // radicand bits
    localparam int NumW = SumW + 8;                 // dividend magnitude bits
    localparam int ItW  = (NumW > RootW) ? NumW : RootW;
    localparam int StepW = $clog2(ItW + 1);
    localparam int RemW = ((RootW + 2) > (CntW + 1)) ? RootW + 2 : CntW + 1;
    localparam int WideW = (NumW > RadW) ? NumW + 2 : RadW + 2;
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LEN);
    localparam logic signed [WideW-1:0] VMax = WideW'(64'sd17179869183);
    localparam logic signed [WideW-1:0] VMin = -WideW'(64'sd17179869184);

    logic signed [SumW-1:0]            sum_reg;
    logic [SqW-1:0]                    sq_reg;
    logic signed [srs_pkg::SampleW-1:0] min_reg, max_reg;
    logic [CntW-1:0]                   cnt_reg;
    logic                              ovf_reg;

    // finish operands
    logic [RadW-1:0]      num_reg;     // dividend magnitude or radicand, shifts out MSB first
    logic [CntW-1:0]      div_reg;
    logic [RemW-1:0]      rem_reg;
    logic [ItW-1:0]       q_reg;
    logic [StepW-1:0]     step_reg;
    logic [srs_pkg::ModeW-1:0] mode_reg;
    logic                 neg_reg, tl_reg;
    logic signed [srs_pkg::ValueW-1:0] value_reg;

    logic signed [2*srs_pkg::SampleW-1:0] prod;
    logic [SqW-1:0]    sq_next;
    logic signed [SumW-1:0] sum_next;
    logic signed [srs_pkg::SampleW-1:0] min_next, max_next;
    logic [CntW-1:0]   cnt_next;
    logic              ovf_next, acc_ok;

    assign acc_ok = cnt_reg != MaxCnt;
    assign prod   = sample * sample;

    always_comb
    begin
        sum_next = sum_reg; sq_next = sq_reg; min_next = min_reg;
        max_next = max_reg; cnt_next = cnt_reg; ovf_next = ovf_reg;
        if (cmd.accum)
        begin
            if (acc_ok)
            begin
                sum_next = sum_reg + SumW'(sample);
                sq_next  = sq_reg + SqW'(unsigned'(prod));
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0 || sample < min_reg) min_next = sample;
                if (cnt_reg == '0 || sample > max_reg) max_next = sample;
            end
            else
                ovf_next = 1'b1;
        end
    end

    // one iteration step: divide (radix 2) or root (digit by digit)
    logic [RemW-1:0] d_trial, r_trial, rem_sh;
    logic            d_ge, r_ge;
    logic            is_mag;
    assign is_mag  = mode_reg == srs_pkg::MODE_MAG;
    always_comb
    begin
        rem_sh  = is_mag ? {rem_reg[RemW-3:0], num_reg[RadW-1 -: 2]}
                         : {rem_reg[RemW-2:0], num_reg[RadW-1]};
        d_trial = RemW'(div_reg);
        r_trial = {q_reg[RemW-3:0], 2'b01};
        d_ge    = rem_sh >= d_trial;
        r_ge    = rem_sh >= r_trial;
    end
    assign stat.iter_done = step_reg == '0;

    logic [StepW-1:0] steps;
    assign steps = (stat_mode == srs_pkg::MODE_MAG) ? StepW'(RootW) : StepW'(NumW);

    // finish value from live accumulators (after last accum, these are next)
    logic signed [WideW-1:0] pre, sat;
    logic [SumW-1:0] abs_sum;
    assign abs_sum = sum_next[SumW-1] ? SumW'(-sum_next) : SumW'(sum_next);

    always_comb
    begin
        case (mode_reg)
            srs_pkg::MODE_MEAN: pre = neg_reg ? -WideW'(q_reg) : WideW'(q_reg);
            srs_pkg::MODE_MAG:  pre = WideW'(q_reg);
            default:            pre = WideW'(value_reg);
        endcase
        sat = (pre > VMax) ? VMax : (pre < VMin) ? VMin : pre;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0; sq_reg <= '0; min_reg <= '0; max_reg <= '0;
            cnt_reg <= '0; ovf_reg <= 1'b0; step_reg <= '0;
        end
        else if (cmd.clear)
        begin
            sum_reg <= '0; sq_reg <= '0; min_reg <= '0; max_reg <= '0;
            cnt_reg <= '0; ovf_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next; sq_reg <= sq_next; min_reg <= min_next;
            max_reg <= max_next; cnt_reg <= cnt_next; ovf_reg <= ovf_next;
            if (cmd.start_fin)
                step_reg <= steps;
            else if (cmd.iter && step_reg != '0)
                step_reg <= step_reg - 1'b1;
        end
    end

    logic signed [WideW-1:0] direct;
    always_comb
    begin
        case (stat_mode)
            srs_pkg::MODE_SUM: direct = WideW'(sum_next) <<< 8;
            srs_pkg::MODE_MIN: direct = WideW'(min_next) <<< 8;
            srs_pkg::MODE_MAX: direct = WideW'(max_next) <<< 8;
            default:           direct = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_fin)
        begin
            mode_reg <= stat_mode;
            neg_reg  <= sum_next[SumW-1];
            tl_reg   <= ovf_next;
            div_reg  <= cnt_next;
            rem_reg  <= '0;
            q_reg    <= '0;
            value_reg <= srs_pkg::ValueW'((direct > VMax) ? VMax
                                         : (direct < VMin) ? VMin : direct);
            if (stat_mode == srs_pkg::MODE_MAG)
                num_reg <= RadW'({sq_next, 16'h0});
            else
                num_reg <= {NumW'({abs_sum, 8'h0}), {(RadW-NumW){1'b0}}};
        end
        else if (cmd.iter && step_reg != '0)
        begin
            if (is_mag)
            begin
                num_reg <= num_reg << 2;
                rem_reg <= r_ge ? rem_sh - r_trial : rem_sh;
                q_reg   <= {q_reg[ItW-2:0], r_ge};
            end
            else
            begin
                num_reg <= num_reg << 1;
                rem_reg <= d_ge ? rem_sh - d_trial : rem_sh;
                q_reg   <= {q_reg[ItW-2:0], d_ge};
            end
        end
        else if (cmd.iter)
        begin
            value_reg <= srs_pkg::ValueW'(sat);
            too_long  <= tl_reg;
        end
    end

    assign value = value_reg;
endmodule

// ----- tb/series_reduction_stats_tb.sv -----
// Testbench for series_reduction_stats: directed table, an over-length series, then random series with a predictor.
// Depends on srs_pkg, srs_if and the series_reduction_stats RTL.
`timescale 1ns / 1ps
module series_reduction_stats_tb;

    localparam int MaxLen = 1024;
    localparam int DrainCycles = 60;
    localparam int RandItems = 50;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam longint ValMax = 64'sd17179869183;
    localparam longint ValMin = -64'sd17179869184;

    typedef struct packed {
        logic signed [srs_pkg::ValueW-1:0] value;
        logic                              too_long;
    } stat_res_t;

    typedef struct packed {
        logic [2:0]                         mode;
        logic signed [srs_pkg::SampleW-1:0] sample;
        logic                               last;
        logic                               known;
        logic signed [srs_pkg::ValueW-1:0]  value;
        logic                               too_long;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic stat_mode_we;
    logic [2:0] stat_mode_wdata;

    srs_in_if  in_ch();
    srs_out_if out_ch();

    series_reduction_stats #(.MAX_LEN(MaxLen)) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .stat_mode_we    (stat_mode_we),
        .stat_mode_wdata (stat_mode_wdata)
    );

    // predictor state
    logic [2:0]      cur_mode;
    longint          acc_sum;
    longint unsigned acc_sq;
    int              acc_min;
    int              acc_max;
    int              acc_cnt;
    logic            acc_ovf;

    stat_res_t pending_q[$];
    int fail_count;
    int items_sent;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    logic hold_req;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #8ms;
        $display("series_reduction_stats_tb: FAIL");
        $finish;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void clear_series();
        acc_sum = 0;
        acc_sq = 0;
        acc_min = 0;
        acc_max = 0;
        acc_cnt = 0;
        acc_ovf = 1'b0;
    endfunction

    // Returns 1 when the sample closes a series, with the statistic in r.
    function automatic bit reduce_sample(input logic signed [srs_pkg::SampleW-1:0] s,
                                         input logic l, output stat_res_t r);
        int sv;
        longint v;
        longint unsigned mag;
        sv = s;
        r = '0;
        if (acc_cnt < MaxLen)
        begin
            if (acc_cnt == 0)
            begin
                acc_min = sv;
                acc_max = sv;
            end
            else
            begin
                if (sv < acc_min) acc_min = sv;
                if (sv > acc_max) acc_max = sv;
            end
            acc_sum += sv;
            acc_sq += longint'(sv) * longint'(sv);
            acc_cnt++;
        end
        else
            acc_ovf = 1'b1;
        if (!l)
            return 0;
        v = 0;
        case (cur_mode)
            srs_pkg::MODE_MEAN:
                if (acc_cnt != 0)
                begin
                    mag = (acc_sum < 0) ? -acc_sum : acc_sum;
                    mag = (mag << 8) / acc_cnt;
                    v = (acc_sum < 0) ? -longint'(mag) : longint'(mag);
                end
            srs_pkg::MODE_SUM: v = acc_sum * 256;
            srs_pkg::MODE_MIN: v = longint'(acc_min) * 256;
            srs_pkg::MODE_MAX: v = longint'(acc_max) * 256;
            srs_pkg::MODE_MAG: v = longint'(floor_sqrt(acc_sq << 16));
            default:           v = 0;
        endcase
        if (v > ValMax) v = ValMax;
        if (v < ValMin) v = ValMin;
        r.value = v[srs_pkg::ValueW-1:0];
        r.too_long = acc_ovf;
        clear_series();
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %0s at %0t: got %0d expected %0d", what, $realtime, got, want);
        fail_count++;
    endtask

    // Called at a falling edge; returns at a falling edge after the item is taken.
    task automatic send_sample(input logic signed [srs_pkg::SampleW-1:0] s, input logic l,
                               input logic known, input stat_res_t want);
        stat_res_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.sample = s;
        in_ch.last = l;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (reduce_sample(s, l, r))
            pending_q.push_back(known ? want : r);
        items_sent++;
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic set_mode(input logic [2:0] m);
        wait_idle();
        stat_mode_we = 1'b1;
        stat_mode_wdata = m;
        @(negedge clk);
        stat_mode_we = 1'b0;
        cur_mode = m;
    endtask

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready = 1'b0;
        end
        else
            out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (pending_q.size() == 0)
                report_mismatch("unexpected result", out_ch.value, 0);
            else
            begin
                if (out_ch.value !== pending_q[0].value)
                    report_mismatch("value", out_ch.value, pending_q[0].value);
                if (out_ch.too_long !== pending_q[0].too_long)
                    report_mismatch("too_long", out_ch.too_long, pending_q[0].too_long);
                void'(pending_q.pop_front());
            end
        end
    end

    task automatic send_series(input int len, input logic full_range);
        logic signed [srs_pkg::SampleW-1:0] s;
        for (int k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 9))
                0: s = 16'sh7FFF;
                1: s = -16'sh8000;
                2, 3: s = 16'($signed($urandom_range(0, 64)) - 32);
                default: s = full_range ? 16'($urandom())
                                        : 16'($signed($urandom_range(0, 2000)) - 1000);
            endcase
            send_sample(s, k == len - 1, 1'b0, '0);
        end
    endtask

    dir_row_t dir_rows[] = '{
        '{srs_pkg::MODE_MEAN, 16'sh7FFF, 1'b1, 1'b1, 35'sd8388352, 1'b0},
        '{srs_pkg::MODE_MEAN, -16'sh8000, 1'b1, 1'b1, -35'sd8388608, 1'b0},
        '{srs_pkg::MODE_MEAN, -16'sd3, 1'b0, 1'b0, '0, 1'b0},
        '{srs_pkg::MODE_MEAN, -16'sd4, 1'b1, 1'b0, '0, 1'b0},
        '{srs_pkg::MODE_SUM, 16'sh7FFF, 1'b0, 1'b0, '0, 1'b0},
        '{srs_pkg::MODE_SUM, 16'sh7FFF, 1'b1, 1'b1, 35'sd16776704, 1'b0},
        '{srs_pkg::MODE_MIN, -16'sh8000, 1'b0, 1'b0, '0, 1'b0},
        '{srs_pkg::MODE_MIN, 16'sd5, 1'b0, 1'b0, '0, 1'b0},
        '{srs_pkg::MODE_MIN, 16'sh7FFF, 1'b1, 1'b1, -35'sd8388608, 1'b0},
        '{srs_pkg::MODE_MAX, -16'sh8000, 1'b0, 1'b0, '0, 1'b0},
        '{srs_pkg::MODE_MAX, 16'sd5, 1'b0, 1'b0, '0, 1'b0},
        '{srs_pkg::MODE_MAX, 16'sh7FFF, 1'b1, 1'b1, 35'sd8388352, 1'b0},
        '{srs_pkg::MODE_MAX, 16'sd0, 1'b1, 1'b1, 35'sd0, 1'b0},
        '{srs_pkg::MODE_MAG, -16'sh8000, 1'b1, 1'b1, 35'sd8388608, 1'b0},
        '{srs_pkg::MODE_MAG, 16'sd3, 1'b0, 1'b0, '0, 1'b0},
        '{srs_pkg::MODE_MAG, -16'sd4, 1'b1, 1'b1, 35'sd1280, 1'b0},
        '{srs_pkg::MODE_MAG, 16'sd2, 1'b1, 1'b0, '0, 1'b0},
        '{MODE_SPARE_LO, 16'sd100, 1'b1, 1'b1, 35'sd0, 1'b0},
        '{MODE_SPARE_HI, -16'sd100, 1'b1, 1'b1, 35'sd0, 1'b0}
    };

    initial
    begin
        stat_res_t want;
        int len;
        int series_done;
        int base;
        rst_n = 1'b0;
        stat_mode_we = 1'b0;
        stat_mode_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        hold_left = 0;
        hold_req = 1'b0;
        fail_count = 0;
        items_sent = 0;
        results_seen = 0;
        send_idle_pct = 7;
        recv_idle_pct = 61;
        cur_mode = srs_pkg::MODE_MEAN;
        clear_series();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset mode is mean, so the first rows run without a write
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].mode != cur_mode)
                set_mode(dir_rows[i].mode);
            want.value = dir_rows[i].value;
            want.too_long = dir_rows[i].too_long;
            send_sample(dir_rows[i].sample, dir_rows[i].last, dir_rows[i].known, want);
        end

        // too many samples: the two samples past MaxLen, the final one included, are dropped
        set_mode(srs_pkg::MODE_SUM);
        for (int k = 0; k < MaxLen + 2; k++)
        begin
            want.value = 35'sd262144;
            want.too_long = 1'b1;
            send_sample(16'sd1, k == MaxLen + 1, k == MaxLen + 1, want);
        end

        series_done = 0;
        base = items_sent;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 61 : 0;
            recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 7 : 0;
            if (phase == 2)
            begin
                // long output stall while short series keep coming
                hold_req = 1'b1;
                for (int k = 0; k < 40; k++)
                    send_series($urandom_range(1, 3), 1'b1);
            end
            while (items_sent < base + (phase + 1) * RandItems)
            begin
                if (series_done % 3 == 0)
                    set_mode(3'($urandom_range(0, 7)));
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(1, 12);
                send_series(len, 1'b1);
                series_done++;
            end
        end
        set_mode(MODE_SPARE_LO);
        set_mode(srs_pkg::MODE_MAG);
        send_series(4, 1'b1);
        wait_idle();

        $display("covered %0d samples, %0d results, one over-length series, all modes",
                 items_sent, results_seen);
        if (fail_count == 0)
            $display("series_reduction_stats_tb: PASS");
        else
            $display("series_reduction_stats_tb: FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
src/srs_pkg.sv
src/srs_if.sv
src/srs_ctrl.sv
src/srs_dp.sv
src/series_reduction_stats.sv
tb/series_reduction_stats_tb.sv
